### src/pidis_pkg.sv
// ----------------------------------------------------------------------------
// pidis_pkg
// shared widths, register indexes, configuration type and saturation helpers
// ----------------------------------------------------------------------------
package pidis_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// field and limit widths are fixed by the interface
	localparam int FIELD_W = 32;
	localparam int LIM_W   = 31;
	localparam int IDX_W   = 3;

	// internal word width, capped at the field width
	localparam int W        = (DATA_WIDTH > FIELD_W) ? FIELD_W :
		((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
	localparam int PROD_W   = FIELD_W + W;
	localparam int SCALED_W = PROD_W - FRAC_BITS;
	localparam int SUM_W    = (SCALED_W + 2 > FIELD_W + 2) ? SCALED_W + 2 : FIELD_W + 2;
	localparam int CMP_W    = ((W > LIM_W) ? W : LIM_W) + 2;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P          = 3'd0,
		REG_GAIN_I          = 3'd1,
		REG_GAIN_D          = 3'd2,
		REG_ERROR_LIMIT     = 3'd3,
		REG_SEPARATION_BAND = 3'd4,
		REG_INTEGRAL_LIMIT  = 3'd5,
		REG_OUTPUT_LIMIT    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [FIELD_W-1:0] gain_p;
		logic [FIELD_W-1:0] gain_i;
		logic [FIELD_W-1:0] gain_d;
		logic [LIM_W-1:0]   error_limit;
		logic [LIM_W-1:0]   separation_band;
		logic [LIM_W-1:0]   integral_limit;
		logic [LIM_W-1:0]   output_limit;
	} cfg_t;

	localparam logic [FIELD_W-1:0] GAIN_P_RST          = FIELD_W'(65536);
	localparam logic [FIELD_W-1:0] GAIN_I_RST          = FIELD_W'(0);
	localparam logic [FIELD_W-1:0] GAIN_D_RST          = FIELD_W'(0);
	localparam logic [LIM_W-1:0]   ERROR_LIMIT_RST     = LIM_W'(3276800);
	localparam logic [LIM_W-1:0]   SEPARATION_BAND_RST = LIM_W'(6553600);
	localparam logic [LIM_W-1:0]   INTEGRAL_LIMIT_RST  = LIM_W'(655360);
	localparam logic [LIM_W-1:0]   OUTPUT_LIMIT_RST    = LIM_W'(65536);

	// saturate a wide signed value to W signed bits
	function automatic logic signed [W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		logic signed [W-1:0]     r;
		hi = {{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			r = hi[W-1:0];
		end else if (v < lo) begin
			r = lo[W-1:0];
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	// symmetric clamp to +/- lim, a zero limit gives zero
	function automatic logic signed [W-1:0] clamp_sym(input logic signed [W-1:0] v,
		input logic [LIM_W-1:0] lim);
		logic signed [CMP_W-1:0] vx;
		logic signed [CMP_W-1:0] lx;
		logic signed [CMP_W-1:0] r;
		vx = {{(CMP_W-W){v[W-1]}}, v};
		lx = {{(CMP_W-LIM_W){1'b0}}, lim};
		r  = vx;
		if (r >= lx) begin
			r = lx;
		end
		if (r <= -lx) begin
			r = -lx;
		end
		return r[W-1:0];
	endfunction

endpackage

### src/pidis_cfg.sv
// ----------------------------------------------------------------------------
// pidis_cfg
// gain and limit registers with their write decode
// ----------------------------------------------------------------------------
module pidis_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pidis_pkg::IDX_W-1:0]      cfg_index,
	input  logic [pidis_pkg::FIELD_W-1:0]    cfg_data,
	output pidis_pkg::cfg_t                  cfg
);

	pidis_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= pidis_pkg::GAIN_P_RST;
			cfg_q.gain_i          <= pidis_pkg::GAIN_I_RST;
			cfg_q.gain_d          <= pidis_pkg::GAIN_D_RST;
			cfg_q.error_limit     <= pidis_pkg::ERROR_LIMIT_RST;
			cfg_q.separation_band <= pidis_pkg::SEPARATION_BAND_RST;
			cfg_q.integral_limit  <= pidis_pkg::INTEGRAL_LIMIT_RST;
			cfg_q.output_limit    <= pidis_pkg::OUTPUT_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pidis_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data;
				end
				pidis_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data;
				end
				pidis_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data;
				end
				pidis_pkg::REG_ERROR_LIMIT: begin
					cfg_q.error_limit <= cfg_data[pidis_pkg::LIM_W-1:0];
				end
				pidis_pkg::REG_SEPARATION_BAND: begin
					cfg_q.separation_band <= cfg_data[pidis_pkg::LIM_W-1:0];
				end
				pidis_pkg::REG_INTEGRAL_LIMIT: begin
					cfg_q.integral_limit <= cfg_data[pidis_pkg::LIM_W-1:0];
				end
				pidis_pkg::REG_OUTPUT_LIMIT: begin
					cfg_q.output_limit <= cfg_data[pidis_pkg::LIM_W-1:0];
				end
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

endmodule

### src/pid_with_integral_separation_core.sv
// ----------------------------------------------------------------------------
// pid_with_integral_separation_core
// positional pid with error clamp, integral separation and output clamp
// pipeline: input register, product register, then drive register before drive is valid
// throughput: one item per cycle while drive_stall holds nothing back, set by the integrator update
// reset: pipeline emptied, integrator and previous error zeroed, registers default
// ----------------------------------------------------------------------------
module pid_with_integral_separation_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [pidis_pkg::FIELD_W-1:0] setpoint,
	input  logic signed [pidis_pkg::FIELD_W-1:0] measured,
	output logic                                 drive_valid,
	input  logic                                 drive_stall,
	output logic signed [pidis_pkg::FIELD_W-1:0] drive,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pidis_pkg::IDX_W-1:0]          cfg_index,
	input  logic [pidis_pkg::FIELD_W-1:0]        cfg_data
);

	localparam int FW = pidis_pkg::FIELD_W;
	localparam int W  = pidis_pkg::W;
	localparam int PW = pidis_pkg::PROD_W;
	localparam int SW = pidis_pkg::SCALED_W;
	localparam int UW = pidis_pkg::SUM_W;
	localparam int CW = pidis_pkg::CMP_W;
	localparam int FB = pidis_pkg::FRAC_BITS;

	pidis_pkg::cfg_t cfg;

	pidis_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline control
	logic vld_s1, vld_s2, drive_valid_q;
	logic en1, en2, en3;
	logic adv1, adv2, adv3;

	assign en3  = !drive_valid_q || !drive_stall;
	assign en2  = !vld_s2 || en3;
	assign en1  = !vld_s1 || en2;
	assign adv1 = sample_valid && en1;
	assign adv2 = vld_s1 && en2;
	assign adv3 = vld_s2 && en3;

	assign sample_stall = !en1;
	assign drive_valid  = drive_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			drive_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= sample_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				drive_valid_q <= vld_s2;
			end
		end
	end

	// input register
	logic signed [FW-1:0] sp_s1, ms_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			sp_s1 <= setpoint;
			ms_s1 <= measured;
		end
	end

	// error, separation test and products
	logic signed [W-1:0]  prev_err_q;
	logic signed [FW:0]   raw_err;
	logic signed [W-1:0]  err_sat, err;
	logic [W:0]           err_mag;
	logic                 sep;
	logic signed [W:0]    dif_raw;
	logic signed [W-1:0]  dif;
	logic signed [PW-1:0] prod_p, prod_i, prod_d;

	assign raw_err = $signed({sp_s1[FW-1], sp_s1}) - $signed({ms_s1[FW-1], ms_s1});
	assign err_sat = pidis_pkg::sat_w(UW'(raw_err));
	assign err     = pidis_pkg::clamp_sym(err_sat, cfg.error_limit);
	assign err_mag = err[W-1] ? (W+1)'(-((W+1)'(err))) : (W+1)'(err);
	assign sep     = CW'(err_mag) <= CW'(cfg.separation_band);
	assign dif_raw = (W+1)'(err) - (W+1)'(prev_err_q);
	assign dif     = pidis_pkg::sat_w(UW'(dif_raw));
	assign prod_p  = $signed(cfg.gain_p) * err;
	assign prod_i  = $signed(cfg.gain_i) * err;
	assign prod_d  = $signed(cfg.gain_d) * dif;

	logic signed [SW-1:0] pp_s2, pi_s2, pd_s2;
	logic                 sep_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			// arithmetic shift right, rounds toward minus infinity
			pp_s2  <= prod_p[PW-1:FB];
			pi_s2  <= prod_i[PW-1:FB];
			pd_s2  <= prod_d[PW-1:FB];
			sep_s2 <= sep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (adv2) begin
			prev_err_q <= err;
		end
	end

	// integrator update and output sum
	logic signed [W-1:0]  integ_q;
	logic signed [UW-1:0] isum;
	logic signed [W-1:0]  integ_pre, integ_nxt;
	logic signed [UW-1:0] osum;
	logic signed [W-1:0]  out_w;

	assign isum      = UW'(integ_q) + UW'(pi_s2);
	assign integ_pre = sep_s2 ? pidis_pkg::sat_w(isum) : integ_q;
	assign integ_nxt = pidis_pkg::clamp_sym(integ_pre, cfg.integral_limit);
	assign osum      = UW'(pp_s2) + UW'(pd_s2) + UW'(integ_nxt);
	assign out_w     = pidis_pkg::clamp_sym(pidis_pkg::sat_w(osum), cfg.output_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (adv3) begin
			integ_q <= integ_nxt;
		end
	end

	logic signed [FW-1:0] drive_q;

	always_ff @(posedge clk) begin
		if (adv3) begin
			drive_q <= FW'(out_w);
		end
	end

	assign drive = drive_q;

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (vld_s1 && vld_s2 && drive_valid_q && drive_stall))
		else $error("input stalled while the pipeline has room");

	a_integ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv3 |=> $stable(integ_q))
		else $error("integrator moved without an item leaving the second stage");

	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv2 |=> $stable(prev_err_q))
		else $error("previous error moved without an item leaving the first stage");

endmodule
